// ===== rtl/array_list_engine_top_defines.svh =====
// ---------------------------------------------------------------------------
// Array list engine assertion macros
// Shared helpers for concurrent checks, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ARRAY_LIST_ENGINE_TOP_DEFINES_SVH
`define ARRAY_LIST_ENGINE_TOP_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define ALEM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define ALEM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/alem_pkg.sv =====
// ---------------------------------------------------------------------------
// Array list engine package
// Field widths, operation and status codes, and sequencer states.
// ---------------------------------------------------------------------------
package alem_pkg;

    localparam int DATA_W           = 32;
    localparam int OP_W             = 3;
    localparam int POS_W            = 7;
    localparam int STATUS_W         = 2;
    localparam int COUNT_W          = 7;
    localparam int CAPACITY_DEFAULT = 64;

    // Operation codes carried by the operation field.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_POP_BACK   = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_INSERT     = 3'd4,
        OP_ERASE      = 3'd5,
        OP_READ       = 3'd6
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STS_OK     = 2'd0,
        STS_FULL   = 2'd1,
        STS_EMPTY  = 2'd2,
        STS_BADPOS = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SHIFT_UP,
        ST_PLACE,
        ST_SHIFT_DN,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/alem_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ---------------------------------------------------------------------------
module alem_ram #(
    parameter int  WIDTH = alem_pkg::DATA_W,
    parameter int  DEPTH = alem_pkg::CAPACITY_DEFAULT,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/array_list_engine_top.sv =====
// ---------------------------------------------------------------------------
// Array list engine
// Dense ordered list of signed 32-bit words with push, pop, insert, erase
// and read, kept in one synchronous RAM.
// ---------------------------------------------------------------------------
// Each accepted word is one list operation and yields exactly one result word.
// Words are handled one at a time. For push back, pop back and failed
// operations, the sequencer goes from execute straight to finish; a read
// passes through the read state. Insert, erase, push front and pop front
// move the tail of the list one element per cycle through the RAM's single
// write port, at most CAPACITY elements. Insert and push front go through
// shift up and place, erase and pop front through shift down, or straight to
// finish when nothing moves. Finish waits for a free output register and
// loads the result into it. A new word is accepted in idle, also while
// the previous result still waits in the output register. Elements are read
// only after they have been written, so the RAM needs no clearing after reset.
module array_list_engine_top #(
    parameter int CAPACITY = alem_pkg::CAPACITY_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [alem_pkg::OP_W-1:0]    operation,
    input  logic [alem_pkg::POS_W-1:0]   position,
    input  logic signed [alem_pkg::DATA_W-1:0] value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [alem_pkg::STATUS_W-1:0] status,
    output logic [alem_pkg::COUNT_W-1:0] count,
    output logic signed [alem_pkg::DATA_W-1:0] read_value
);

`include "array_list_engine_top_defines.svh"

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > alem_pkg::POS_W) ? CW : alem_pkg::POS_W;

    alem_pkg::state_t state_reg, state_next;

    logic [alem_pkg::OP_W-1:0]   op_reg;
    logic [alem_pkg::POS_W-1:0]  pos_reg;
    logic [alem_pkg::DATA_W-1:0] val_reg;
    logic [CW-1:0]               count_reg;
    logic [AW-1:0]               cursor_reg;
    alem_pkg::status_t           res_status_reg;
    logic [alem_pkg::DATA_W-1:0] res_rdval_reg;

    logic                          out_valid_reg;
    logic [alem_pkg::STATUS_W-1:0] status_reg;
    logic [alem_pkg::COUNT_W-1:0]  count_out_reg;
    logic [alem_pkg::DATA_W-1:0]   read_value_reg;

    logic                        mem_wr_en;
    logic [AW-1:0]               mem_wr_addr;
    logic [alem_pkg::DATA_W-1:0] mem_wr_data;
    logic                        mem_rd_en;
    logic [AW-1:0]               mem_rd_addr;
    logic [alem_pkg::DATA_W-1:0] mem_rd_data;

    logic              count_inc;
    logic              count_dec;
    logic              in_fire;
    logic              out_free;
    logic [XW-1:0]     count_x;
    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     pos_m1;
    logic [CW-1:0]     count_m1;
    logic [AW-1:0]     idx;
    logic [AW-1:0]     last;
    logic              is_full;
    logic              is_empty;
    logic              pos_ok;
    logic              front_op;
    logic              idx_at_end;
    logic              idx_at_last;
    alem_pkg::status_t exec_status;

    // Element store.
    alem_ram #(
        .WIDTH (alem_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Decode of the held operation against the current count.
    assign count_x     = XW'(count_reg);
    assign pos_x       = XW'(pos_reg);
    assign pos_m1      = pos_x - XW'(1);
    assign count_m1    = count_reg - CW'(1);
    assign is_full     = count_reg >= CW'(CAPACITY);
    assign is_empty    = count_reg == '0;
    assign pos_ok      = (pos_x != '0) && (pos_x <= count_x);
    assign front_op    = (op_reg == alem_pkg::OP_PUSH_FRONT) ||
                         (op_reg == alem_pkg::OP_POP_FRONT);
    assign idx         = front_op ? '0 : pos_m1[AW-1:0];
    assign last        = count_m1[AW-1:0];
    assign idx_at_end  = CW'(idx) == count_reg;
    assign idx_at_last = idx == last;

    // Status of the held operation, full and empty checked before position.
    always_comb
    begin
        exec_status = alem_pkg::STS_OK;
        case (op_reg)
            alem_pkg::OP_PUSH_BACK,
            alem_pkg::OP_PUSH_FRONT:
            begin
                if (is_full) exec_status = alem_pkg::STS_FULL;
            end
            alem_pkg::OP_POP_BACK,
            alem_pkg::OP_POP_FRONT:
            begin
                if (is_empty) exec_status = alem_pkg::STS_EMPTY;
            end
            alem_pkg::OP_INSERT:
            begin
                if (is_full)      exec_status = alem_pkg::STS_FULL;
                else if (!pos_ok) exec_status = alem_pkg::STS_BADPOS;
            end
            alem_pkg::OP_ERASE,
            alem_pkg::OP_READ:
            begin
                if (is_empty)     exec_status = alem_pkg::STS_EMPTY;
                else if (!pos_ok) exec_status = alem_pkg::STS_BADPOS;
            end
            default:
            begin
                exec_status = alem_pkg::STS_OK;
            end
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            alem_pkg::ST_IDLE:
            begin
                if (in_valid) state_next = alem_pkg::ST_EXEC;
            end
            alem_pkg::ST_EXEC:
            begin
                state_next = alem_pkg::ST_FINISH;
                if (exec_status == alem_pkg::STS_OK)
                begin
                    case (op_reg)
                        alem_pkg::OP_READ:
                        begin
                            state_next = alem_pkg::ST_READ;
                        end
                        alem_pkg::OP_PUSH_FRONT,
                        alem_pkg::OP_INSERT:
                        begin
                            if (!idx_at_end) state_next = alem_pkg::ST_SHIFT_UP;
                        end
                        alem_pkg::OP_POP_FRONT,
                        alem_pkg::OP_ERASE:
                        begin
                            if (!idx_at_last) state_next = alem_pkg::ST_SHIFT_DN;
                        end
                        default:
                        begin
                            state_next = alem_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            alem_pkg::ST_READ:
            begin
                state_next = alem_pkg::ST_FINISH;
            end
            alem_pkg::ST_SHIFT_UP:
            begin
                if (cursor_reg == idx) state_next = alem_pkg::ST_PLACE;
            end
            alem_pkg::ST_PLACE:
            begin
                state_next = alem_pkg::ST_FINISH;
            end
            alem_pkg::ST_SHIFT_DN:
            begin
                if (cursor_reg == last) state_next = alem_pkg::ST_FINISH;
            end
            alem_pkg::ST_FINISH:
            begin
                if (out_free) state_next = alem_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = alem_pkg::ST_IDLE;
            end
        endcase
    end

    // Output logic: RAM accesses and count updates for each state.
    // Shifting up reads downward and writes one above; shifting down reads
    // upward and writes one below, so a write never hits a pending read.
    always_comb
    begin
        in_ready    = state_reg == alem_pkg::ST_IDLE;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = mem_rd_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        count_inc   = 1'b0;
        count_dec   = 1'b0;
        case (state_reg)
            alem_pkg::ST_EXEC:
            begin
                if (exec_status == alem_pkg::STS_OK)
                begin
                    case (op_reg)
                        alem_pkg::OP_PUSH_BACK:
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = count_reg[AW-1:0];
                            mem_wr_data = val_reg;
                            count_inc   = 1'b1;
                        end
                        alem_pkg::OP_POP_BACK:
                        begin
                            count_dec = 1'b1;
                        end
                        alem_pkg::OP_PUSH_FRONT,
                        alem_pkg::OP_INSERT:
                        begin
                            if (idx_at_end)
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = idx;
                                mem_wr_data = val_reg;
                                count_inc   = 1'b1;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = last;
                            end
                        end
                        alem_pkg::OP_POP_FRONT,
                        alem_pkg::OP_ERASE:
                        begin
                            if (idx_at_last)
                            begin
                                count_dec = 1'b1;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = idx + AW'(1);
                            end
                        end
                        alem_pkg::OP_READ:
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = idx;
                        end
                        default:
                        begin
                            mem_rd_en = 1'b0;
                        end
                    endcase
                end
            end
            alem_pkg::ST_SHIFT_UP:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cursor_reg + AW'(1);
                if (cursor_reg != idx)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = cursor_reg - AW'(1);
                end
            end
            alem_pkg::ST_PLACE:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = idx;
                mem_wr_data = val_reg;
                count_inc   = 1'b1;
            end
            alem_pkg::ST_SHIFT_DN:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cursor_reg - AW'(1);
                if (cursor_reg != last)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = cursor_reg + AW'(1);
                end
                else
                begin
                    count_dec = 1'b1;
                end
            end
            default:
            begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    // Control state: sequencer, element count and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= alem_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (count_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (count_dec)
            begin
                count_reg <= count_m1;
            end
            if (state_reg == alem_pkg::ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: held word, read cursor, pending result and output word.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= operation;
            pos_reg <= position;
            val_reg <= value;
        end
        if (mem_rd_en)
        begin
            cursor_reg <= mem_rd_addr;
        end
        if (state_reg == alem_pkg::ST_EXEC)
        begin
            res_status_reg <= exec_status;
            res_rdval_reg  <= '0;
        end
        else if (state_reg == alem_pkg::ST_READ)
        begin
            res_rdval_reg <= mem_rd_data;
        end
        if (state_reg == alem_pkg::ST_FINISH && out_free)
        begin
            status_reg     <= res_status_reg;
            count_out_reg  <= count_x[alem_pkg::COUNT_W-1:0];
            read_value_reg <= res_rdval_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign count      = count_out_reg;
    assign read_value = read_value_reg;

    // Checks on the sequencer and the store.
    `ALEM_ASSERT(a_count_bound, count_reg <= CW'(CAPACITY),
        "element count exceeds capacity")
    `ALEM_ASSERT(a_no_idle_write,
        !mem_wr_en || (state_reg != alem_pkg::ST_IDLE && state_reg != alem_pkg::ST_FINISH),
        "RAM written while no operation is in progress")
    `ALEM_ASSERT_NEXT(a_accept_exec, in_fire, state_reg == alem_pkg::ST_EXEC,
        "accepted word did not start execution")
    `ALEM_ASSERT_NEXT(a_finish_out, state_reg == alem_pkg::ST_FINISH && out_free,
        out_valid_reg && state_reg == alem_pkg::ST_IDLE,
        "finished result was not presented")

endmodule
